FILE: rtl/round_robin_thread_slot_scheduler_top_assert.svh
// assertion macros for the slot scheduler
`ifndef ROUND_ROBIN_THREAD_SLOT_SCHEDULER_TOP_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SLOT_SCHEDULER_TOP_ASSERT_SVH

// implication checked every clock outside reset
`define RRS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the cycle after the antecedent
`define RRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rrs_pkg.sv
// ---------------------------------------------------------------------------
// rrs_pkg
// types and codes shared by the slot scheduler modules
// ---------------------------------------------------------------------------
package rrs_pkg;

   localparam int SLOT_W = 4;
   localparam int PIDF_W = 16;

   localparam logic [2:0] OP_CREATE   = 3'd0;
   localparam logic [2:0] OP_YIELD    = 3'd1;
   localparam logic [2:0] OP_EXIT     = 3'd2;
   localparam logic [2:0] OP_KILL     = 3'd3;
   localparam logic [2:0] OP_REAP_ALL = 3'd4;
   localparam logic [2:0] OP_FIND     = 3'd5;
   localparam logic [2:0] OP_REAP_ONE = 3'd6;

   localparam logic [1:0] ST_UNUSED   = 2'd0;
   localparam logic [1:0] ST_RUNNABLE = 2'd1;
   localparam logic [1:0] ST_RUNNING  = 2'd2;
   localparam logic [1:0] ST_ZOMBIE   = 2'd3;

   localparam logic [1:0] RS_OK      = 2'd0;
   localparam logic [1:0] RS_NO_SLOT = 2'd1;
   localparam logic [1:0] RS_REFUSED = 2'd2;
   localparam logic [1:0] RS_PID_OUT = 2'd3;

   typedef struct packed {
      logic [2:0]        op;
      logic [PIDF_W-1:0] target_pid;
      logic signed [31:0] exit_value;
      logic [SLOT_W-1:0] target_slot;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [PIDF_W-1:0] pid;
      logic              switched;
      logic [SLOT_W-1:0] running_slot;
      logic [1:0]        found_state;
      logic signed [31:0] found_exit_value;
      logic [3:0]        reaped_count;
   } rsp_type;

   // controller commands to the datapath
   typedef struct packed {
      logic load;      // latch request, clear result
      logic reap_step; // free scan slot if zombie
      logic find_step; // compare scan slot pid
      logic walk_step; // advance walk pointer
      logic scan_rst;  // restart scan index
      logic finish;    // apply the operation using gathered facts
   } rrs_cmd_type;

   // datapath status to the controller
   typedef struct packed {
      logic scan_last;
      logic walk_done;
   } rrs_sts_type;

endpackage

FILE: rtl/round_robin_thread_slot_scheduler_top.sv
// ---------------------------------------------------------------------------
// round_robin_thread_slot_scheduler_top
// task slot table with an insertion-ordered run ring, one request at a time
// ---------------------------------------------------------------------------
// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   req_data (req_type)
// rsp_      out        rsp_valid/rsp_stall   rsp_data (rsp_type)
//
// create, reap all and find scan every slot once before the result
// yield, exit, reap slot and unknown ops walk the ring one link per cycle
// kill scans pids then walks the ring
// the result leaves at its first unstalled edge, then the block returns to idle
// reset is synchronous and restores the idle task as the only live slot
// req_stall stays high while a request is in work or its result is held
// ---------------------------------------------------------------------------
module round_robin_thread_slot_scheduler_top
   import rrs_pkg::*;
#(
   parameter int MAX_SLOTS = 16,
   parameter int PID_BITS  = 16
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   rrs_cmd_type cmd;
   rrs_sts_type sts;

   // sequencer
   rrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_data.op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // slot table and walk logic
   rrs_datapath #(
      .MAX_SLOTS (MAX_SLOTS),
      .PID_BITS  (PID_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

FILE: rtl/rrs_ctrl.sv
// ---------------------------------------------------------------------------
// rrs_ctrl
// operation sequencer: reap scan, pid search, ring walk, commit
// ---------------------------------------------------------------------------
module rrs_ctrl
   import rrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rrs_cmd_type cmd,
   input  rrs_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE, S_REAP, S_FIND, S_WALK, S_FINISH, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [2:0] op_ff, op_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load     = 1'b1;
               cmd.scan_rst = 1'b1;
               op_in        = req_op;
               if (req_op == OP_CREATE || req_op == OP_REAP_ALL) begin
                  state_in = S_REAP;
               end else if (req_op == OP_KILL || req_op == OP_FIND) begin
                  state_in = S_FIND;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_REAP: begin
            cmd.reap_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_FINISH;
            end
         end
         S_FIND: begin
            cmd.find_step = 1'b1;
            if (sts.scan_last) begin
               state_in = (op_ff == OP_KILL) ? S_WALK : S_FINISH;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         op_ff        <= OP_CREATE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
      end
   end

`include "round_robin_thread_slot_scheduler_top_assert.svh"
   `RRS_ASSERT_IMP(a_out_valid, clock, reset, state_ff == S_OUT, rsp_valid_ff, "out without valid")
   `RRS_ASSERT_NEXT(a_finish_out, clock, reset, state_ff == S_FINISH, state_ff == S_OUT, "finish lost")
   `RRS_ASSERT_IMP(a_valid_busy, clock, reset, rsp_valid_ff, req_stall, "accept while result held")

endmodule

FILE: rtl/rrs_datapath.sv
// ---------------------------------------------------------------------------
// rrs_datapath
// slot table, ring links and the per-step scan and walk logic
// ---------------------------------------------------------------------------
module rrs_datapath
   import rrs_pkg::*;
#(
   parameter int MAX_SLOTS = 16,
   parameter int PID_BITS  = 16
)(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  rrs_cmd_type cmd,
   output rrs_sts_type sts,
   output rsp_type     rsp_data
);

   localparam int IW = $clog2(MAX_SLOTS);
   localparam int CW = PID_BITS + 1;
   localparam int GW = $clog2(MAX_SLOTS + 1);

   logic [1:0]          st_ff   [MAX_SLOTS];
   logic [1:0]          st_in   [MAX_SLOTS];
   logic [PID_BITS-1:0] pid_ff  [MAX_SLOTS];
   logic [PID_BITS-1:0] pid_in  [MAX_SLOTS];
   logic [31:0]         ex_ff   [MAX_SLOTS];
   logic [31:0]         ex_in   [MAX_SLOTS];
   logic [IW-1:0]       lnk_ff  [MAX_SLOTS];
   logic [IW-1:0]       lnk_in  [MAX_SLOTS];
   logic [IW-1:0]       tail_ff, tail_in;
   logic [IW-1:0]       cur_ff, cur_in;
   logic [CW-1:0]       cnt_ff, cnt_in;

   req_type       rq_ff, rq_in;
   rsp_type       rs_ff, rs_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          fnd_ff, fnd_in;
   logic [IW-1:0] fidx_ff, fidx_in;
   logic          free_ff, free_in;
   logic [IW-1:0] fslot_ff, fslot_in;
   logic [3:0]    reap_ff, reap_in;
   // ring walk: next live after target, predecessor of target
   logic [IW-1:0] wp_ff, wp_in;
   logic [GW-1:0] wg_ff, wg_in;
   logic          nxf_ff, nxf_in;
   logic [IW-1:0] nx_ff, nx_in;
   logic          prf_ff, prf_in;
   logic [IW-1:0] pr_ff, pr_in;
   logic [IW-1:0] tgt_ff, tgt_in;
   logic          wdone;
   logic          live_wp;

   assign rsp_data = rs_ff;
   assign sts.scan_last = (idx_ff == IW'(MAX_SLOTS - 1));
   assign live_wp = (st_ff[wp_ff] == ST_RUNNABLE) || (st_ff[wp_ff] == ST_RUNNING);
   assign wdone = (wg_ff == GW'(MAX_SLOTS)) || (nxf_ff && prf_ff);
   assign sts.walk_done = wdone;

   always_comb begin
      logic [IW-1:0] t;
      logic [IW-1:0] nx;
      logic          sw;
      logic          do_exit;
      logic          wt;
      st_in = st_ff; pid_in = pid_ff; ex_in = ex_ff; lnk_in = lnk_ff;
      tail_in = tail_ff; cur_in = cur_ff; cnt_in = cnt_ff;
      rq_in = rq_ff; rs_in = rs_ff; idx_in = idx_ff;
      fnd_in = fnd_ff; fidx_in = fidx_ff; free_in = free_ff; fslot_in = fslot_ff;
      reap_in = reap_ff; wp_in = wp_ff; wg_in = wg_ff; nxf_in = nxf_ff; nx_in = nx_ff;
      prf_in = prf_ff; pr_in = pr_ff; tgt_in = tgt_ff;
      t = '0; nx = '0; sw = 1'b0; do_exit = 1'b0; wt = 1'b0;

      if (cmd.load) begin
         rq_in = req_data; rs_in = '0; fnd_in = 1'b0; fidx_in = '0;
         free_in = 1'b0; fslot_in = '0; reap_in = '0;
         tgt_in = cur_ff; wp_in = lnk_ff[cur_ff]; wg_in = '0;
         nxf_in = 1'b0; nx_in = cur_ff; prf_in = 1'b0; pr_in = '0;
         // yield needs no predecessor, so its predecessor search starts as done
         if (req_data.op == OP_YIELD) prf_in = 1'b1;
      end
      if (cmd.scan_rst) idx_in = '0;
      if (cmd.reap_step) begin
         if (idx_ff != '0 && st_ff[idx_ff] == ST_ZOMBIE) begin
            st_in[idx_ff] = ST_UNUSED; pid_in[idx_ff] = '0;
            ex_in[idx_ff] = '0; lnk_in[idx_ff] = '0;
            if (reap_ff != 4'd15) reap_in = reap_ff + 4'd1;
         end
         if (idx_ff != '0 && !free_ff &&
             (st_ff[idx_ff] == ST_ZOMBIE || st_ff[idx_ff] == ST_UNUSED)) begin
            free_in = 1'b1; fslot_in = idx_ff;
         end
         idx_in = idx_ff + IW'(1);
      end
      if (cmd.find_step) begin
         if (!fnd_ff && st_ff[idx_ff] != ST_UNUSED &&
             PIDF_W'(pid_ff[idx_ff]) == rq_ff.target_pid) begin
            fnd_in = 1'b1; fidx_in = idx_ff;
            if (rq_ff.op == OP_KILL) begin
               tgt_in = idx_ff; wp_in = lnk_ff[idx_ff];
            end
         end
         idx_in = idx_ff + IW'(1);
      end
      if (cmd.walk_step) begin
         // next live after target (stops at target)
         if (!nxf_ff) begin
            if (wp_ff == tgt_ff) begin
               nxf_in = 1'b1; nx_in = tgt_ff;
            end else if (live_wp) begin
               nxf_in = 1'b1; nx_in = wp_ff;
            end
         end
         // predecessor: slot whose link is target
         if (!prf_ff && lnk_ff[wp_ff] == tgt_ff) begin
            prf_in = 1'b1; pr_in = wp_ff;
         end
         wp_in = lnk_ff[wp_ff];
         wg_in = wg_ff + GW'(1);
      end
      if (cmd.finish) begin
         rs_in.reaped_count = reap_ff;
         case (rq_ff.op)
            OP_CREATE: begin
               if (!free_ff) begin
                  rs_in.status = RS_NO_SLOT;
               end else if (cnt_ff[PID_BITS]) begin
                  rs_in.status = RS_PID_OUT;
               end else begin
                  t = fslot_ff;
                  rs_in.slot = SLOT_W'(t);
                  rs_in.pid = PIDF_W'(cnt_ff[PID_BITS-1:0]);
                  cnt_in = cnt_ff + CW'(1);
                  pid_in[t] = cnt_ff[PID_BITS-1:0];
                  st_in[t] = ST_RUNNABLE; ex_in[t] = '0;
                  lnk_in[t] = lnk_ff[tail_ff];
                  lnk_in[tail_ff] = t;
                  tail_in = t;
               end
            end
            OP_YIELD: begin
               if (nx_ff != cur_ff) begin
                  sw = 1'b1;
                  if (st_ff[cur_ff] == ST_RUNNING) st_in[cur_ff] = ST_RUNNABLE;
                  st_in[nx_ff] = ST_RUNNING; cur_in = nx_ff;
               end
               rs_in.slot = SLOT_W'(sw ? nx_ff : cur_ff);
            end
            OP_EXIT: begin
               do_exit = 1'b1; wt = 1'b1;
            end
            OP_KILL: begin
               if (!fnd_ff || fidx_ff == '0 || st_ff[fidx_ff] == ST_ZOMBIE) begin
                  rs_in.status = RS_REFUSED;
               end else begin
                  rs_in.slot = SLOT_W'(fidx_ff);
                  rs_in.pid = PIDF_W'(pid_ff[fidx_ff]);
                  if (fidx_ff == cur_ff) begin
                     do_exit = 1'b1;
                  end else begin
                     t = fidx_ff;
                     if (lnk_ff[t] != t && prf_ff) begin
                        lnk_in[pr_ff] = lnk_ff[t];
                        if (tail_ff == t) tail_in = pr_ff;
                        lnk_in[t] = '0;
                     end
                     ex_in[t] = rq_ff.exit_value; st_in[t] = ST_ZOMBIE;
                  end
               end
            end
            OP_REAP_ALL: ;
            OP_FIND: begin
               if (!fnd_ff) begin
                  rs_in.status = RS_REFUSED;
               end else begin
                  rs_in.slot = SLOT_W'(fidx_ff);
                  rs_in.pid = PIDF_W'(pid_ff[fidx_ff]);
                  rs_in.found_state = st_ff[fidx_ff];
                  rs_in.found_exit_value = ex_ff[fidx_ff];
               end
            end
            OP_REAP_ONE: begin
               if (rq_ff.target_slot == '0 || 32'(rq_ff.target_slot) >= MAX_SLOTS ||
                   st_ff[IW'(rq_ff.target_slot)] != ST_ZOMBIE) begin
                  rs_in.status = RS_REFUSED;
               end else begin
                  t = IW'(rq_ff.target_slot);
                  st_in[t] = ST_UNUSED; pid_in[t] = '0; ex_in[t] = '0; lnk_in[t] = '0;
                  rs_in.reaped_count = 4'd1;
               end
            end
            default: rs_in.status = RS_REFUSED;
         endcase
         if (do_exit) begin
            t = cur_ff;
            if (t == '0) begin
               // exit from idle is a plain yield
               if (nx_ff != cur_ff) begin
                  sw = 1'b1; st_in[t] = ST_RUNNABLE;
                  st_in[nx_ff] = ST_RUNNING; cur_in = nx_ff;
               end
            end else begin
               sw = 1'b1;
               nx = (nx_ff == t) ? '0 : nx_ff;
               if (lnk_ff[t] != t && prf_ff) begin
                  lnk_in[pr_ff] = lnk_ff[t];
                  if (tail_ff == t) tail_in = pr_ff;
                  lnk_in[t] = '0;
               end
               st_in[t] = ST_ZOMBIE; ex_in[t] = rq_ff.exit_value;
               st_in[nx] = ST_RUNNING; cur_in = nx;
            end
            if (wt) rs_in.slot = SLOT_W'(sw ? (t == '0 ? nx_ff : nx) : cur_ff);
         end
         rs_in.switched = sw;
         rs_in.running_slot = SLOT_W'(cur_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            st_ff[i] <= (i == 0) ? ST_RUNNING : ST_UNUSED;
            ex_ff[i] <= '0; lnk_ff[i] <= '0;
         end
         pid_ff[0] <= '0;
         tail_ff <= '0; cur_ff <= '0; cnt_ff <= CW'(1);
      end else begin
         st_ff <= st_in; ex_ff <= ex_in; lnk_ff <= lnk_in; pid_ff <= pid_in;
         tail_ff <= tail_in; cur_ff <= cur_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rq_ff <= rq_in; rs_ff <= rs_in; idx_ff <= idx_in; fnd_ff <= fnd_in;
      fidx_ff <= fidx_in; free_ff <= free_in; fslot_ff <= fslot_in; reap_ff <= reap_in;
      wp_ff <= wp_in; wg_ff <= wg_in; nxf_ff <= nxf_in; nx_ff <= nx_in;
      prf_ff <= prf_in; pr_ff <= pr_in; tgt_ff <= tgt_in;
   end

`include "round_robin_thread_slot_scheduler_top_assert.svh"
   `RRS_ASSERT_IMP(a_idle_live, clock, reset, 1'b1, st_ff[0] != ST_UNUSED && st_ff[0] != ST_ZOMBIE, "idle slot lost")
   `RRS_ASSERT_IMP(a_cur_running, clock, reset, 1'b1, st_ff[cur_ff] == ST_RUNNING, "current not running")
   `RRS_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CW'(1) << PID_BITS, "pid counter overrun")

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the round-robin slot scheduler: a behavioral copy
// of the slot table predicts each result and a small scoreboard compares them
// ---------------------------------------------------------------------------
module tb_top;
   import rrs_pkg::*;

   localparam int NSLOT = 16;
   localparam int PIDB  = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   // predicted slot table
   class slot_table_board;
      logic [1:0]  st_q [NSLOT];
      logic [15:0] pid_q [NSLOT];
      logic [31:0] xv_q [NSLOT];
      int          link_q [NSLOT];
      int          tail, cur;
      int          pid_ctr;
      rsp_type     pending [$];
      int          errors;

      function new();
         for (int i = 0; i < NSLOT; i++) begin
            st_q[i] = ST_UNUSED; pid_q[i] = 0; xv_q[i] = 0; link_q[i] = 0;
         end
         st_q[0] = ST_RUNNING;
         tail = 0; cur = 0; pid_ctr = 1; errors = 0;
      endfunction

      function bit live(int s);
         return st_q[s] == ST_RUNNABLE || st_q[s] == ST_RUNNING;
      endfunction

      function int pick_after(int c);
         int n;
         n = link_q[c];
         for (int g = 0; g < NSLOT && n != c; g++) begin
            if (live(n)) return n;
            n = link_q[n];
         end
         return c;
      endfunction

      function void unlink(int t);
         int p;
         p = tail;
         if (link_q[t] == t) return;
         for (int g = 0; g < NSLOT; g++) begin
            if (link_q[p] == t) begin
               link_q[p] = link_q[t];
               if (tail == t) tail = p;
               link_q[t] = 0;
               return;
            end
            p = link_q[p];
            if (p == tail) return;
         end
      endfunction

      function void free_one(int s);
         st_q[s] = ST_UNUSED; pid_q[s] = 0; xv_q[s] = 0; link_q[s] = 0;
      endfunction

      function int reap_zombies();
         int n;
         n = 0;
         for (int i = 1; i < NSLOT; i++)
            if (st_q[i] == ST_ZOMBIE) begin free_one(i); n++; end
         return n > 15 ? 15 : n;
      endfunction

      function bit yield_now();
         int nx;
         nx = pick_after(cur);
         if (nx == cur) return 0;
         if (st_q[cur] == ST_RUNNING) st_q[cur] = ST_RUNNABLE;
         st_q[nx] = ST_RUNNING;
         cur = nx;
         return 1;
      endfunction

      function bit exit_now(logic [31:0] code);
         int nx, prev;
         prev = cur;
         if (prev == 0) return yield_now();
         nx = pick_after(prev);
         unlink(prev);
         st_q[prev] = ST_ZOMBIE;
         xv_q[prev] = code;
         if (nx == prev) nx = 0;
         st_q[nx] = ST_RUNNING;
         cur = nx;
         return 1;
      endfunction

      function int lookup(logic [15:0] p);
         for (int i = 0; i < NSLOT; i++)
            if (st_q[i] != ST_UNUSED && pid_q[i] == p) return i;
         return -1;
      endfunction

      // apply one accepted request and queue its predicted result
      function void note_request(req_type r);
         rsp_type o;
         int f, i;
         o = '0;
         case (r.op)
            OP_CREATE: begin
               o.reaped_count = 4'(reap_zombies());
               for (i = 1; i < NSLOT; i++) if (st_q[i] == ST_UNUSED) break;
               if (i >= NSLOT) o.status = RS_NO_SLOT;
               else if (pid_ctr >= (1 << PIDB)) o.status = RS_PID_OUT;
               else begin
                  o.slot = SLOT_W'(i); o.pid = PIDF_W'(pid_ctr); pid_ctr++;
                  pid_q[i] = o.pid; st_q[i] = ST_RUNNABLE; xv_q[i] = 0;
                  link_q[i] = link_q[tail]; link_q[tail] = i; tail = i;
               end
            end
            OP_YIELD: begin o.switched = yield_now(); o.slot = SLOT_W'(cur); end
            OP_EXIT: begin o.switched = exit_now(r.exit_value); o.slot = SLOT_W'(cur); end
            OP_KILL: begin
               f = lookup(r.target_pid);
               if (f <= 0 || st_q[f] == ST_ZOMBIE) o.status = RS_REFUSED;
               else begin
                  o.slot = SLOT_W'(f); o.pid = pid_q[f];
                  if (f == cur) o.switched = exit_now(r.exit_value);
                  else begin
                     unlink(f); xv_q[f] = r.exit_value; st_q[f] = ST_ZOMBIE;
                  end
               end
            end
            OP_REAP_ALL: o.reaped_count = 4'(reap_zombies());
            OP_FIND: begin
               f = lookup(r.target_pid);
               if (f < 0) o.status = RS_REFUSED;
               else begin
                  o.slot = SLOT_W'(f); o.pid = pid_q[f]; o.found_state = st_q[f];
                  o.found_exit_value = xv_q[f];
               end
            end
            OP_REAP_ONE: begin
               if (r.target_slot == 0 || st_q[r.target_slot] != ST_ZOMBIE)
                  o.status = RS_REFUSED;
               else begin free_one(int'(r.target_slot)); o.reaped_count = 1; end
            end
            default: o.status = RS_REFUSED;
         endcase
         o.running_slot = SLOT_W'(cur);
         pending.push_back(o);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t: result mismatch expected %h actual %h", $time, want, got);
            if (got.status !== want.status)
               $display("%0t:   status expected %0d actual %0d", $time, want.status, got.status);
            if (got.slot !== want.slot)
               $display("%0t:   slot expected %0d actual %0d", $time, want.slot, got.slot);
            if (got.pid !== want.pid)
               $display("%0t:   pid expected %0d actual %0d", $time, want.pid, got.pid);
            if (got.switched !== want.switched)
               $display("%0t:   switched expected %0d actual %0d", $time,
                        want.switched, got.switched);
            if (got.running_slot !== want.running_slot)
               $display("%0t:   running_slot expected %0d actual %0d", $time,
                        want.running_slot, got.running_slot);
            if (got.found_state !== want.found_state)
               $display("%0t:   found_state expected %0d actual %0d", $time,
                        want.found_state, got.found_state);
            if (got.found_exit_value !== want.found_exit_value)
               $display("%0t:   found_exit_value expected %h actual %h", $time,
                        want.found_exit_value, got.found_exit_value);
            if (got.reaped_count !== want.reaped_count)
               $display("%0t:   reaped_count expected %0d actual %0d", $time,
                        want.reaped_count, got.reaped_count);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   slot_table_board board;
   int  send_idle_pct;   // chance in a hundred that the sender idles
   int  recv_stall_pct;  // chance in a hundred that the receiver stalls
   int  cycle_count;
   int  pid_seen;        // highest pid handed out so far, for pid targeting

   round_robin_thread_slot_scheduler_top #(
      .MAX_SLOTS(NSLOT),
      .PID_BITS (PIDB)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run guard
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // receiver: random stall driven at the falling edge
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // result monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_data);
   end

   // send one request; the board is updated at the accepting edge
   // valid stays high afterward until the next idle cycle or drain
   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      if (r.op == OP_CREATE && board.pending[$].status == RS_OK)
         pid_seen = int'(board.pending[$].pid);
      @(negedge clock);
   endtask

   task automatic send_op(logic [2:0] op, logic [15:0] tpid, logic [31:0] xv,
                          logic [3:0] ts);
      req_type r;
      r.op = op; r.target_pid = tpid; r.exit_value = xv; r.target_slot = ts;
      send_request(r);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   // random request with the op mix weighted toward live scheduling
   task automatic send_random();
      int pick;
      logic [2:0]  op;
      logic [15:0] tpid;
      pick = $urandom_range(99);
      if (pick < 22) op = OP_CREATE;
      else if (pick < 40) op = OP_YIELD;
      else if (pick < 52) op = OP_EXIT;
      else if (pick < 70) op = OP_KILL;
      else if (pick < 75) op = OP_REAP_ALL;
      else if (pick < 86) op = OP_FIND;
      else if (pick < 97) op = OP_REAP_ONE;
      else op = OP_UNUSED;
      // mostly name a recent pid so that kill and find hit live slots
      if ($urandom_range(9) < 8 && pid_seen > 0)
         tpid = 16'($urandom_range(pid_seen, (pid_seen > 20) ? pid_seen - 20 : 0));
      else
         tpid = 16'($urandom);
      send_op(op, tpid, $urandom, 4'($urandom_range(15)));
   endtask

   initial begin
      board = new();
      pid_seen = 0;
      send_idle_pct = 32;
      recv_stall_pct = 74;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle-only yield and exit, lookups, refusals
      send_op(OP_YIELD, 16'd0, 32'd0, 4'd0);
      send_op(OP_EXIT, 16'd0, 32'h7fffffff, 4'd0);
      send_op(OP_FIND, 16'd0, 32'd0, 4'd0);
      send_op(OP_KILL, 16'd0, 32'd5, 4'd0);
      send_op(OP_FIND, 16'hffff, 32'd0, 4'd0);
      send_op(OP_REAP_ONE, 16'd0, 32'd0, 4'd0);
      send_op(OP_REAP_ONE, 16'd0, 32'd0, 4'd15);
      send_op(OP_UNUSED, 16'hffff, 32'hffffffff, 4'hf);
      // fill the table, then one create too many
      for (int i = 0; i < 15; i++) send_op(OP_CREATE, 16'd0, 32'd0, 4'd0);
      send_op(OP_CREATE, 16'd0, 32'd0, 4'd0);
      send_op(OP_YIELD, 16'd0, 32'd0, 4'd0);
      send_op(OP_EXIT, 16'd0, 32'h80000000, 4'd0);
      send_op(OP_KILL, 16'd5, 32'hffffffff, 4'd0);
      send_op(OP_KILL, 16'd5, 32'd1, 4'd0);
      send_op(OP_FIND, 16'd5, 32'd0, 4'd0);
      send_op(OP_REAP_ONE, 16'd0, 32'd0, 4'd5);
      send_op(OP_REAP_ALL, 16'd0, 32'd0, 4'd0);

      // hold off until every result has come back
      drain_results();

      for (int n = 0; n < 950; n++) begin
         if (n == 320) begin send_idle_pct = 74; recv_stall_pct = 32; end
         if (n == 640) begin send_idle_pct = 0; recv_stall_pct = 0; end
         send_random();
      end

      // a last create and lookups of a pid that was never handed out
      send_op(OP_CREATE, 16'd0, 32'd0, 4'd0);
      send_op(OP_FIND, 16'hffff, 32'd0, 4'd0);
      send_op(OP_KILL, 16'hffff, 32'd0, 4'd0);

      drain_results();
      repeat (3 * NSLOT) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rrs_pkg.sv
rtl/rrs_ctrl.sv
rtl/rrs_datapath.sv
rtl/round_robin_thread_slot_scheduler_top.sv
verif/tb_top.sv
